/* design/fpts_pkg.sv */
// ----------------------------------------------------------------------------
// fpts_pkg
// shared types and constants of the feedback priority thread scheduler
// ----------------------------------------------------------------------------
package fpts_pkg;

  localparam int unsigned THREAD_SLOTS_DEF = 16;
  localparam int unsigned EVENT_COUNT_DEF  = 8;

  localparam logic [15:0] QUANTUM_LOW_RST  = 16'd300;
  localparam logic [15:0] QUANTUM_MID_RST  = 16'd200;
  localparam logic [15:0] QUANTUM_HIGH_RST = 16'd100;
  localparam logic [7:0]  TICK_STEP_RST    = 8'd10;

  typedef enum logic [3:0] {
    OP_CREATE      = 4'd0,
    OP_CANCEL      = 4'd1,
    OP_WAIT_EVENT  = 4'd2,
    OP_SET_EVENT   = 4'd3,
    OP_WAIT_TICKS  = 4'd4,
    OP_TEST_CANCEL = 4'd5,
    OP_FINISH      = 4'd6,
    OP_TICK        = 4'd7,
    OP_DISPATCH    = 4'd8,
    OP_QUERY       = 4'd9,
    OP_RECLAIM     = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    CFG_QUANTUM_LOW  = 2'd0,
    CFG_QUANTUM_MID  = 2'd1,
    CFG_QUANTUM_HIGH = 2'd2,
    CFG_TICK_STEP    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NO_SLOT  = 3'd1,
    STS_IGNORED  = 3'd2,
    STS_NO_RUN   = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SL_FREE  = 3'd0,
    SL_READY = 3'd1,
    SL_RUN   = 3'd2,
    SL_WAIT  = 3'd3,
    SL_TERM  = 3'd4
  } slot_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAKE,
    S_APPLY,
    S_DONE
  } fsm_t;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_slot;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic [2:0]  slot_status;
    logic [1:0]  base_level;
    logic [1:0]  current_level;
    logic [31:0] ready_time;
    logic [31:0] blocked_time;
    logic        level_changed;
  } res_t;

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* design/fpts_if.sv */
// ----------------------------------------------------------------------------
// fpts_in_if / fpts_out_if
// request and result channels of the thread scheduler
// ----------------------------------------------------------------------------
interface fpts_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [1:0]  priority_req;
  logic        defer_cancel;
  logic [3:0]  thread_slot;
  logic [2:0]  event_number;
  logic [15:0] wait_ticks;
  modport source(output valid, op, priority_req, defer_cancel, thread_slot, event_number,
                 wait_ticks, input ready);
  modport sink(input valid, op, priority_req, defer_cancel, thread_slot, event_number,
               wait_ticks, output ready);
endinterface

interface fpts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  result_slot;
  logic        running_valid;
  logic [3:0]  running_slot;
  logic [2:0]  slot_status;
  logic [1:0]  base_level;
  logic [1:0]  current_level;
  logic [31:0] ready_time;
  logic [31:0] blocked_time;
  logic        level_changed;
  modport source(output valid, status, result_slot, running_valid, running_slot,
                 slot_status, base_level, current_level, ready_time, blocked_time,
                 level_changed, input ready);
  modport sink(input valid, status, result_slot, running_valid, running_slot,
               slot_status, base_level, current_level, ready_time, blocked_time,
               level_changed, output ready);
endinterface

/* design/fpts_pick.sv */
// ----------------------------------------------------------------------------
// fpts_pick
// shared compare unit: highest current level first, then oldest entry
// ----------------------------------------------------------------------------
module fpts_pick
  import fpts_pkg::*;
(
  input  logic        cand,
  input  logic [1:0]  cand_lvl,
  input  logic [31:0] cand_stamp,
  input  logic [31:0] stamp_now,
  input  logic        best_v,
  input  logic [1:0]  best_lvl,
  input  logic [31:0] best_age,
  output logic        take,
  output logic [31:0] cand_age
);
  assign cand_age = stamp_now - cand_stamp;
  assign take = cand && (!best_v || (cand_lvl > best_lvl) ||
                         ((cand_lvl == best_lvl) && (cand_age > best_age)));
endmodule

/* design/feedback_priority_thread_scheduler.sv */
// ----------------------------------------------------------------------------
// feedback_priority_thread_scheduler
// multilevel feedback thread scheduler over a table of thread slots
// ----------------------------------------------------------------------------
// one command is taken on in_req when valid and ready are high; one result
// leaves on out_res. the slot table is walked one entry per cycle through a
// single access port and a shared level/age compare unit.
// direct commands (cancel, wait, finish, query, test) go through S_APPLY to
// S_DONE, or straight to S_DONE when rejected at once; create, set_event and
// dispatch scan the table in S_SCAN and then apply; reclaim and a scan that
// finds nothing go from S_SCAN to S_DONE; a tick scans the table, then makes
// a wake pass in S_WAKE, each woken thread costing one more table pass.
// in_req.ready is high only while no command is in work; one command at a
// time. the result sits in an output register until taken and the next
// command is taken meanwhile; its result waits in the final state while the
// previous one is still pending on a stalled receiver.
// reset: all slots free, nothing running, quanta 300/200/100, tick step 10.
// configuration is written on cfg_we with cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module feedback_priority_thread_scheduler
  import fpts_pkg::*;
#(
  parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF,
  parameter int unsigned EVENT_COUNT  = EVENT_COUNT_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  fpts_in_if.sink     in_req,
  fpts_out_if.source  out_res
);
  localparam int unsigned SW   = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned EW   = $clog2(EVENT_COUNT + 1);
  localparam logic [SW-1:0] LAST = SW'(THREAD_SLOTS - 1);
  localparam logic [EW-1:0] NOT_WAITING = EW'(EVENT_COUNT);

  typedef struct packed {
    logic [2:0]  st;
    logic [1:0]  init_lvl;
    logic [1:0]  pres_lvl;
    logic        deferred;
    logic        pending;
    logic [EW-1:0] awaited;
    logic [15:0] target;
    logic [15:0] count;
    logic [31:0] stamp;
    logic [31:0] queued;
    logic [31:0] waited;
  } entry_t;

  entry_t      tab_r [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] due_r, due_nxt;

  logic [15:0] quanta_r [3];
  logic [7:0]  step_r;

  fsm_t        state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [1:0]  preq_r, preq_nxt;
  logic        cmode_r, cmode_nxt;
  logic [2:0]  ev_r, ev_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        best_v_r, best_v_nxt;
  logic [SW-1:0] best_idx_r, best_idx_nxt;
  logic [1:0]  best_lvl_r, best_lvl_nxt;
  logic [31:0] best_age_r, best_age_nxt;
  logic        run_r, run_nxt;
  logic [SW-1:0] run_id_r, run_id_nxt;
  logic [15:0] qe_r, qe_nxt;
  logic [31:0] sc_r, sc_nxt;
  res_t        res_r, res_nxt;
  res_t        out_r, out_nxt;
  logic        out_v_r, out_v_nxt;

  entry_t rd, wr;
  logic   we;
  logic   cand, take;
  logic [31:0] cand_age;
  logic [16:0] qe_sum;
  logic [1:0]  lv;
  logic        ev_ok;

  assign rd = tab_r[idx_r];

  fpts_pick u_pick (
    .cand(cand), .cand_lvl(rd.pres_lvl), .cand_stamp(rd.stamp), .stamp_now(sc_r),
    .best_v(best_v_r), .best_lvl(best_lvl_r), .best_age(best_age_r),
    .take(take), .cand_age(cand_age)
  );

  always_comb begin
    cand = 1'b0;
    case (state_r)
      S_SCAN: begin
        case (op_r)
          OP_SET_EVENT: cand = (rd.st == SL_WAIT) && (rd.target == 16'd0) &&
                               (32'(rd.awaited) == 32'(ev_r));
          OP_DISPATCH:  cand = (rd.st == SL_READY);
          default:      cand = 1'b0;
        endcase
      end
      S_WAKE:  cand = due_r[idx_r] && (rd.st == SL_WAIT);
      default: cand = 1'b0;
    endcase
  end

  assign ev_ok  = 32'(in_req.event_number) < EVENT_COUNT;
  assign qe_sum = {1'b0, qe_r} + {9'd0, step_r};
  assign lv     = (rd.pres_lvl > LVL_HIGH) ? LVL_HIGH : rd.pres_lvl;
  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;  idx_nxt = idx_r;
    op_nxt = op_r; preq_nxt = preq_r; cmode_nxt = cmode_r;
    ev_nxt = ev_r; ticks_nxt = ticks_r;
    best_v_nxt = best_v_r; best_idx_nxt = best_idx_r;
    best_lvl_nxt = best_lvl_r; best_age_nxt = best_age_r;
    run_nxt = run_r; run_id_nxt = run_id_r; qe_nxt = qe_r; sc_nxt = sc_r;
    res_nxt = res_r; out_nxt = out_r; out_v_nxt = out_v_r; due_nxt = due_r;
    we = 1'b0; wr = rd;

    if (out_v_r && out_res.ready) out_v_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt = in_req.op; preq_nxt = in_req.priority_req;
          cmode_nxt = in_req.defer_cancel;
          ev_nxt = in_req.event_number; ticks_nxt = in_req.wait_ticks;
          res_nxt = '0; best_v_nxt = 1'b0; idx_nxt = '0;
          case (in_req.op)
            OP_CREATE, OP_RECLAIM: state_nxt = S_SCAN;
            OP_CANCEL: begin
              if (in_req.thread_slot == 4'd0 || 32'(in_req.thread_slot) >= THREAD_SLOTS) begin
                res_nxt.status = STS_IGNORED; state_nxt = S_DONE;
              end else begin
                idx_nxt = SW'(in_req.thread_slot); state_nxt = S_APPLY;
              end
            end
            OP_WAIT_EVENT, OP_WAIT_TICKS, OP_TEST_CANCEL, OP_FINISH: begin
              if (!run_r) begin
                res_nxt.status = STS_NO_RUN; state_nxt = S_DONE;
              end else if (in_req.op == OP_WAIT_EVENT && !ev_ok) begin
                res_nxt.status = STS_IGNORED; state_nxt = S_DONE;
              end else begin
                idx_nxt = run_id_r; state_nxt = S_APPLY;
              end
            end
            OP_SET_EVENT: begin
              if (!ev_ok) begin
                res_nxt.status = STS_IGNORED; state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_TICK: begin
              qe_nxt = qe_sum[16] ? 16'hFFFF : qe_sum[15:0];
              state_nxt = S_SCAN;
            end
            OP_DISPATCH: begin
              if (run_r) begin
                res_nxt.status = STS_IGNORED; state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_QUERY: begin
              if (32'(in_req.thread_slot) >= THREAD_SLOTS) begin
                res_nxt.status = STS_IGNORED; state_nxt = S_DONE;
              end else begin
                idx_nxt = SW'(in_req.thread_slot); state_nxt = S_APPLY;
              end
            end
            default: begin
              res_nxt.status = STS_IGNORED; state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (op_r)
          OP_CREATE: begin
            if (rd.st == SL_FREE && !best_v_r) begin
              best_v_nxt = 1'b1; best_idx_nxt = idx_r;
            end
          end
          OP_TICK: begin
            we = 1'b1;
            due_nxt[idx_r] = 1'b0;
            if (rd.st == SL_READY) begin
              wr.queued = add_sat32(rd.queued, step_r);
            end else if (rd.st == SL_WAIT) begin
              wr.waited = add_sat32(rd.waited, step_r);
              if (rd.target != 16'd0) begin
                if (rd.count != 16'hFFFF) wr.count = rd.count + 16'd1;
                due_nxt[idx_r] = (wr.count >= rd.target);
              end
            end
          end
          OP_RECLAIM: begin
            if (rd.st == SL_TERM) begin
              we = 1'b1;
              wr = '0;
              wr.st = SL_FREE;
              wr.awaited = NOT_WAITING;
            end
          end
          default: begin
            if (take) begin
              best_v_nxt = 1'b1; best_idx_nxt = idx_r;
              best_lvl_nxt = rd.pres_lvl; best_age_nxt = cand_age;
            end
          end
        endcase
        if (idx_r == LAST) begin
          case (op_r)
            OP_TICK: begin
              idx_nxt = '0; best_v_nxt = 1'b0; state_nxt = S_WAKE;
            end
            OP_RECLAIM: state_nxt = S_DONE;
            default: begin
              if (best_v_nxt) begin
                idx_nxt = best_idx_nxt; state_nxt = S_APPLY;
              end else begin
                res_nxt.status = (op_r == OP_CREATE) ? STS_NO_SLOT :
                                 (op_r == OP_DISPATCH) ? STS_EMPTY : STS_IGNORED;
                state_nxt = S_DONE;
              end
            end
          endcase
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_WAKE: begin
        if (take) begin
          best_v_nxt = 1'b1; best_idx_nxt = idx_r;
          best_lvl_nxt = rd.pres_lvl; best_age_nxt = cand_age;
        end
        if (idx_r == LAST) begin
          if (best_v_nxt) begin
            idx_nxt = best_idx_nxt; state_nxt = S_APPLY;
          end else if (run_r) begin
            idx_nxt = run_id_r; state_nxt = S_APPLY;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_APPLY: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_CREATE: begin
            we = 1'b1;
            wr = '0;
            wr.st = SL_READY;
            wr.init_lvl = (preq_r == 2'd3) ? LVL_LOW : preq_r;
            wr.pres_lvl = (preq_r == 2'd3) ? LVL_LOW : preq_r;
            wr.deferred = cmode_r;
            wr.awaited = NOT_WAITING;
            wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
            res_nxt.result_slot = 4'(idx_r);
          end
          OP_CANCEL: begin
            if (rd.st != SL_READY && rd.st != SL_WAIT) begin
              res_nxt.status = STS_IGNORED;
            end else if (rd.deferred) begin
              we = 1'b1; wr.pending = 1'b1;
            end else begin
              we = 1'b1; wr.st = SL_TERM; wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
            end
          end
          OP_WAIT_EVENT, OP_WAIT_TICKS: begin
            we = 1'b1;
            if (qe_r < quanta_r[lv]) begin
              if (lv < LVL_HIGH) begin
                wr.pres_lvl = lv + 2'd1; res_nxt.level_changed = 1'b1;
              end
            end else if (lv > LVL_LOW) begin
              wr.pres_lvl = lv - 2'd1; res_nxt.level_changed = 1'b1;
            end
            if (op_r == OP_WAIT_EVENT) begin
              wr.awaited = EW'(ev_r); wr.target = 16'd0;
            end else begin
              wr.awaited = NOT_WAITING;
              wr.target = (ticks_r == 16'd0) ? 16'd1 : ticks_r;
            end
            wr.count = 16'd0;
            wr.st = SL_WAIT; wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
            run_nxt = 1'b0; run_id_nxt = '0;
          end
          OP_SET_EVENT: begin
            we = 1'b1;
            wr.awaited = NOT_WAITING;
            wr.st = SL_READY; wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
            res_nxt.result_slot = 4'(idx_r);
          end
          OP_TEST_CANCEL, OP_FINISH: begin
            if (op_r == OP_TEST_CANCEL && !rd.pending) begin
              res_nxt.status = STS_IGNORED;
            end else begin
              we = 1'b1;
              wr.st = SL_TERM; wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
              run_nxt = 1'b0; run_id_nxt = '0;
            end
          end
          OP_TICK: begin
            if (best_v_r) begin
              we = 1'b1;
              wr.target = 16'd0; wr.count = 16'd0;
              wr.st = SL_READY; wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
              due_nxt[idx_r] = 1'b0;
              best_v_nxt = 1'b0; idx_nxt = '0; state_nxt = S_WAKE;
            end else if (qe_r >= quanta_r[lv]) begin
              we = 1'b1;
              if (lv > LVL_LOW) begin
                wr.pres_lvl = lv - 2'd1; res_nxt.level_changed = 1'b1;
              end
              wr.st = SL_READY; wr.stamp = sc_r; sc_nxt = sc_r + 32'd1;
              run_nxt = 1'b0; run_id_nxt = '0;
            end
          end
          OP_DISPATCH: begin
            we = 1'b1; wr.st = SL_RUN;
            run_nxt = 1'b1; run_id_nxt = idx_r; qe_nxt = 16'd0;
          end
          OP_QUERY: begin
            res_nxt.result_slot = 4'(idx_r);
            res_nxt.slot_status = rd.st;
            res_nxt.base_level = rd.init_lvl;
            res_nxt.current_level = rd.pres_lvl;
            res_nxt.ready_time = rd.queued;
            res_nxt.blocked_time = rd.waited;
          end
          default: ;
        endcase
      end

      S_DONE: begin
        if (!out_v_r || out_res.ready) begin
          res_nxt.running_valid = run_r;
          res_nxt.running_slot = run_r ? 4'(run_id_r) : 4'd0;
          out_nxt = res_nxt;
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r <= 1'b0; run_id_r <= '0; qe_r <= '0; sc_r <= '0;
      out_v_r <= 1'b0; best_v_r <= 1'b0; due_r <= '0; idx_r <= '0;
      quanta_r[0] <= QUANTUM_LOW_RST;
      quanta_r[1] <= QUANTUM_MID_RST;
      quanta_r[2] <= QUANTUM_HIGH_RST;
      step_r <= TICK_STEP_RST;
    end else begin
      state_r <= state_nxt;
      run_r <= run_nxt; run_id_r <= run_id_nxt; qe_r <= qe_nxt; sc_r <= sc_nxt;
      out_v_r <= out_v_nxt; best_v_r <= best_v_nxt; due_r <= due_nxt; idx_r <= idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM_LOW:  quanta_r[0] <= cfg_data;
          CFG_QUANTUM_MID:  quanta_r[1] <= cfg_data;
          CFG_QUANTUM_HIGH: quanta_r[2] <= cfg_data;
          CFG_TICK_STEP:    step_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; preq_r <= preq_nxt; cmode_r <= cmode_nxt;
    ev_r <= ev_nxt; ticks_r <= ticks_nxt;
    best_idx_r <= best_idx_nxt; best_lvl_r <= best_lvl_nxt; best_age_r <= best_age_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // slot table; order stamps need no reset, the rest is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        tab_r[i].st <= SL_FREE;
        tab_r[i].init_lvl <= '0; tab_r[i].pres_lvl <= '0;
        tab_r[i].deferred <= 1'b0; tab_r[i].pending <= 1'b0;
        tab_r[i].awaited <= NOT_WAITING;
        tab_r[i].target <= '0; tab_r[i].count <= '0;
        tab_r[i].queued <= '0; tab_r[i].waited <= '0;
      end
    end else if (we) begin
      tab_r[idx_r] <= wr;
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.status        = out_r.status;
  assign out_res.result_slot   = out_r.result_slot;
  assign out_res.running_valid = out_r.running_valid;
  assign out_res.running_slot  = out_r.running_slot;
  assign out_res.slot_status   = out_r.slot_status;
  assign out_res.base_level    = out_r.base_level;
  assign out_res.current_level = out_r.current_level;
  assign out_res.ready_time    = out_r.ready_time;
  assign out_res.blocked_time  = out_r.blocked_time;
  assign out_res.level_changed = out_r.level_changed;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the feedback priority thread scheduler. a directed
// table covers the extremes and every command, then constrained-by-hand
// random traffic runs under four quantum settings. every result is checked
// against an in-bench model of the slot table, or for fixed directed rows
// against the values in the table, with random stalls both sides
module testbench;
  import fpts_pkg::*;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  priority_req;
    logic        defer_cancel;
    logic [3:0]  thread_slot;
    logic [2:0]  event_number;
    logic [15:0] wait_ticks;
  } cmd_t;

  typedef struct {
    cmd_t c;
    bit   fixed;
    res_t r;
  } row_t;

  localparam int NSLOT = 16;
  localparam logic [3:0] NO_EVENT = 4'd8;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fpts_in_if  req_if();
  fpts_out_if res_if();

  feedback_priority_thread_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_req(req_if.sink), .out_res(res_if.source)
  );

  // scheduler model state
  logic [15:0] m_quanta [3];
  logic [7:0]  m_step;
  logic [2:0]  m_state [NSLOT];
  logic [1:0]  m_base [NSLOT];
  logic [1:0]  m_level [NSLOT];
  logic        m_deferred [NSLOT];
  logic        m_pending [NSLOT];
  logic [3:0]  m_event [NSLOT];
  logic [15:0] m_target [NSLOT];
  logic [15:0] m_count [NSLOT];
  logic [31:0] m_stamp [NSLOT];
  logic [31:0] m_queued [NSLOT];
  logic [31:0] m_waited [NSLOT];
  logic [3:0]  m_run_id;
  logic        m_running;
  logic [15:0] m_elapsed;
  logic [31:0] m_stamp_ctr;

  res_t result_q[$];
  row_t dir_rows[$];
  int   sent, checked, errors, cycles;
  bit   quiet;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int head_slot(logic [2:0] want, logic [15:0] mask);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (m_state[i] != want || !mask[i]) continue;
      age = m_stamp_ctr - m_stamp[i];
      if (best < 0 || m_level[i] > m_level[best] ||
          (m_level[i] == m_level[best] && age > best_age)) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic void enqueue(int s, logic [2:0] st);
    m_state[s] = st;
    m_stamp[s] = m_stamp_ctr;
    m_stamp_ctr++;
  endfunction

  function automatic void wipe_slot(int s);
    m_state[s] = SL_FREE;
    m_base[s] = 0;
    m_level[s] = 0;
    m_deferred[s] = 0;
    m_pending[s] = 0;
    m_event[s] = NO_EVENT;
    m_target[s] = 0;
    m_count[s] = 0;
    m_stamp[s] = 0;
    m_queued[s] = 0;
    m_waited[s] = 0;
  endfunction

  function automatic void sched_reset();
    m_quanta[0] = 16'd300;
    m_quanta[1] = 16'd200;
    m_quanta[2] = 16'd100;
    m_step = 8'd10;
    for (int i = 0; i < NSLOT; i++) wipe_slot(i);
    m_running = 0;
    m_run_id = 0;
    m_elapsed = 0;
    m_stamp_ctr = 0;
  endfunction

  function automatic void leave_cpu();
    m_running = 0;
    m_run_id = 0;
  endfunction

  function automatic bit feedback(int s);
    logic [1:0] lv;
    lv = m_level[s] > 2 ? 2'd2 : m_level[s];
    if (m_elapsed < m_quanta[lv]) begin
      if (lv < 2) begin
        m_level[s] = lv + 2'd1;
        return 1;
      end
    end else if (lv > 0) begin
      m_level[s] = lv - 2'd1;
      return 1;
    end
    return 0;
  endfunction

  function automatic res_t schedule(cmd_t c);
    res_t r;
    int s;
    logic [15:0] mask;
    logic [16:0] e;
    logic [1:0] lv;
    r = '0;
    s = -1;
    case (c.op)
      OP_CREATE: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (m_state[i] == SL_FREE) s = i;
        if (s < 0) r.status = STS_NO_SLOT;
        else begin
          wipe_slot(s);
          m_base[s] = c.priority_req == 2'd3 ? LVL_LOW : c.priority_req;
          m_level[s] = m_base[s];
          m_deferred[s] = c.defer_cancel;
          enqueue(s, SL_READY);
          r.result_slot = 4'(s);
        end
      end
      OP_CANCEL: begin
        if (c.thread_slot == 0 ||
            (m_state[c.thread_slot] != SL_READY && m_state[c.thread_slot] != SL_WAIT))
          r.status = STS_IGNORED;
        else if (m_deferred[c.thread_slot]) m_pending[c.thread_slot] = 1;
        else enqueue(c.thread_slot, SL_TERM);
      end
      OP_WAIT_EVENT, OP_WAIT_TICKS: begin
        if (!m_running) r.status = STS_NO_RUN;
        else begin
          r.level_changed = feedback(m_run_id);
          if (c.op == OP_WAIT_EVENT) begin
            m_event[m_run_id] = {1'b0, c.event_number};
            m_target[m_run_id] = 0;
          end else begin
            m_event[m_run_id] = NO_EVENT;
            m_target[m_run_id] = c.wait_ticks == 0 ? 16'd1 : c.wait_ticks;
          end
          m_count[m_run_id] = 0;
          enqueue(m_run_id, SL_WAIT);
          leave_cpu();
        end
      end
      OP_SET_EVENT: begin
        for (int i = 0; i < NSLOT; i++)
          mask[i] = m_target[i] == 0 && m_event[i] == {1'b0, c.event_number};
        s = head_slot(SL_WAIT, mask);
        if (s < 0) r.status = STS_IGNORED;
        else begin
          m_event[s] = NO_EVENT;
          enqueue(s, SL_READY);
          r.result_slot = 4'(s);
        end
      end
      OP_TEST_CANCEL: begin
        if (!m_running) r.status = STS_NO_RUN;
        else if (!m_pending[m_run_id]) r.status = STS_IGNORED;
        else begin
          enqueue(m_run_id, SL_TERM);
          leave_cpu();
        end
      end
      OP_FINISH: begin
        if (!m_running) r.status = STS_NO_RUN;
        else begin
          enqueue(m_run_id, SL_TERM);
          leave_cpu();
        end
      end
      OP_TICK: begin
        e = m_elapsed + m_step;
        m_elapsed = e > 17'h0FFFF ? 16'hFFFF : e[15:0];
        mask = '0;
        for (int i = 0; i < NSLOT; i++) begin
          if (m_state[i] == SL_READY) m_queued[i] = sat_sum(m_queued[i], m_step);
          else if (m_state[i] == SL_WAIT) begin
            m_waited[i] = sat_sum(m_waited[i], m_step);
            if (m_target[i] != 0) begin
              if (m_count[i] != 16'hFFFF) m_count[i]++;
              mask[i] = m_count[i] >= m_target[i];
            end
          end
        end
        s = head_slot(SL_WAIT, mask);
        while (s >= 0) begin
          mask[s] = 0;
          m_target[s] = 0;
          m_count[s] = 0;
          enqueue(s, SL_READY);
          s = head_slot(SL_WAIT, mask);
        end
        if (m_running) begin
          lv = m_level[m_run_id] > 2 ? 2'd2 : m_level[m_run_id];
          if (m_elapsed >= m_quanta[lv]) begin
            if (lv > 0) begin
              m_level[m_run_id] = lv - 2'd1;
              r.level_changed = 1;
            end
            enqueue(m_run_id, SL_READY);
            leave_cpu();
          end
        end
      end
      OP_DISPATCH: begin
        if (m_running) r.status = STS_IGNORED;
        else begin
          s = head_slot(SL_READY, '1);
          if (s < 0) r.status = STS_EMPTY;
          else begin
            m_state[s] = SL_RUN;
            m_run_id = 4'(s);
            m_running = 1;
            m_elapsed = 0;
          end
        end
      end
      OP_QUERY: begin
        r.result_slot = c.thread_slot;
        r.slot_status = m_state[c.thread_slot];
        r.base_level = m_base[c.thread_slot];
        r.current_level = m_level[c.thread_slot];
        r.ready_time = m_queued[c.thread_slot];
        r.blocked_time = m_waited[c.thread_slot];
      end
      OP_RECLAIM: begin
        for (int i = 0; i < NSLOT; i++) if (m_state[i] == SL_TERM) wipe_slot(i);
      end
      default: r.status = STS_IGNORED;
    endcase
    r.running_valid = m_running;
    r.running_slot = m_running ? m_run_id : 4'd0;
    return r;
  endfunction

  function automatic cmd_t mk(logic [3:0] op, logic [1:0] pr, logic cm, logic [3:0] sl,
                              logic [2:0] ev, logic [15:0] tk);
    cmd_t c;
    c.op = op;
    c.priority_req = pr;
    c.defer_cancel = cm;
    c.thread_slot = sl;
    c.event_number = ev;
    c.wait_ticks = tk;
    return c;
  endfunction

  function automatic void add_row(cmd_t c, bit fixed = 0, logic [2:0] st = STS_OK,
                                  logic [3:0] rs = 0);
    row_t w;
    w.c = c;
    w.fixed = fixed;
    w.r = '0;
    w.r.status = st;
    w.r.result_slot = rs;
    dir_rows.push_back(w);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c = $bits(cmd_t)'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) c.op = OP_CREATE;
    else if (pick < 22) c.op = OP_CANCEL;
    else if (pick < 30) c.op = OP_WAIT_EVENT;
    else if (pick < 40) c.op = OP_SET_EVENT;
    else if (pick < 48) c.op = OP_WAIT_TICKS;
    else if (pick < 53) c.op = OP_TEST_CANCEL;
    else if (pick < 58) c.op = OP_FINISH;
    else if (pick < 74) c.op = OP_TICK;
    else if (pick < 89) c.op = OP_DISPATCH;
    else if (pick < 95) c.op = OP_QUERY;
    else if (pick < 98) c.op = OP_RECLAIM;
    else c.op = 4'($urandom_range(15, 11));
    if ($urandom_range(9) != 0) c.wait_ticks = 16'($urandom_range(4));
    return c;
  endfunction

  task automatic send_req(cmd_t c, bit fixed, res_t r);
    res_t p;
    while (!quiet && $urandom_range(99) < 28) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op <= c.op;
    req_if.priority_req <= c.priority_req;
    req_if.defer_cancel <= c.defer_cancel;
    req_if.thread_slot <= c.thread_slot;
    req_if.event_number <= c.event_number;
    req_if.wait_ticks <= c.wait_ticks;
    do @(posedge clk); while (!req_if.ready);
    p = schedule(c);
    result_q.push_back(fixed ? r : p);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICK_STEP) m_step = val[7:0];
    else m_quanta[idx] = val;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) res_if.ready <= (quiet || !rst_n) ? 1'b1 : ($urandom_range(99) >= 28);

  // result checker
  always @(posedge clk) begin
    res_t e;
    bit bad;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status %0d", res_if.status);
      end else begin
        e = result_q.pop_front();
        bad = e.status != res_if.status || e.result_slot != res_if.result_slot ||
              e.running_valid != res_if.running_valid ||
              e.running_slot != res_if.running_slot || e.slot_status != res_if.slot_status ||
              e.base_level != res_if.base_level || e.current_level != res_if.current_level ||
              e.ready_time != res_if.ready_time || e.blocked_time != res_if.blocked_time ||
              e.level_changed != res_if.level_changed;
        checked++;
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at result %0d", checked);
            $display("  exp st%0d rs%0d rv%0d run%0d ss%0d b%0d c%0d rt%0d bt%0d lc%0d",
                     e.status, e.result_slot, e.running_valid, e.running_slot,
                     e.slot_status, e.base_level, e.current_level, e.ready_time,
                     e.blocked_time, e.level_changed);
            $display("  got st%0d rs%0d rv%0d run%0d ss%0d b%0d c%0d rt%0d bt%0d lc%0d",
                     res_if.status, res_if.result_slot,
                     res_if.running_valid, res_if.running_slot, res_if.slot_status,
                     res_if.base_level, res_if.current_level, res_if.ready_time,
                     res_if.blocked_time, res_if.level_changed);
          end
        end
      end
    end
  end

  initial begin
    res_t none;
    none = '0;
    sent = 0;
    checked = 0;
    errors = 0;
    cycles = 0;
    quiet = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_QUANTUM_LOW;
    cfg_data <= '0;
    req_if.valid <= 1'b0;
    req_if.op <= OP_QUERY;
    req_if.priority_req <= '0;
    req_if.defer_cancel <= 1'b0;
    req_if.thread_slot <= '0;
    req_if.event_number <= '0;
    req_if.wait_ticks <= '0;
    sched_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests
    add_row(mk(OP_DISPATCH, 0, 0, 0, 0, 0), 1, STS_EMPTY);
    add_row(mk(OP_QUERY, 0, 0, 15, 0, 0), 1, STS_OK, 15);
    add_row(mk(4'd11, 3, 1, 15, 7, 16'hFFFF), 1, STS_IGNORED);
    add_row(mk(4'd15, 0, 0, 0, 0, 0), 1, STS_IGNORED);
    add_row(mk(OP_CANCEL, 0, 0, 0, 0, 0), 1, STS_IGNORED);
    add_row(mk(OP_FINISH, 0, 0, 0, 0, 0), 1, STS_NO_RUN);
    add_row(mk(OP_TEST_CANCEL, 0, 0, 0, 0, 0), 1, STS_NO_RUN);
    add_row(mk(OP_WAIT_EVENT, 0, 0, 0, 7, 0), 1, STS_NO_RUN);
    add_row(mk(OP_CREATE, 2, 0, 0, 0, 0), 1, STS_OK, 0);
    add_row(mk(OP_CREATE, 3, 1, 0, 0, 0), 1, STS_OK, 1);
    add_row(mk(OP_CREATE, 0, 0, 0, 0, 0));
    add_row(mk(OP_CREATE, 1, 1, 0, 0, 0));
    add_row(mk(OP_DISPATCH, 0, 0, 0, 0, 0));
    add_row(mk(OP_DISPATCH, 0, 0, 0, 0, 0));
    add_row(mk(OP_WAIT_TICKS, 0, 0, 0, 0, 0));
    add_row(mk(OP_DISPATCH, 0, 0, 0, 0, 0));
    add_row(mk(OP_WAIT_EVENT, 0, 0, 0, 7, 0));
    add_row(mk(OP_SET_EVENT, 0, 0, 0, 0, 0));
    add_row(mk(OP_TICK, 0, 0, 0, 0, 0));
    add_row(mk(OP_SET_EVENT, 0, 0, 0, 7, 0));
    add_row(mk(OP_CANCEL, 0, 0, 3, 0, 0));
    add_row(mk(OP_CANCEL, 0, 0, 2, 0, 0));
    add_row(mk(OP_DISPATCH, 0, 0, 0, 0, 0));
    add_row(mk(OP_WAIT_TICKS, 0, 0, 0, 0, 16'hFFFF));
    add_row(mk(OP_QUERY, 0, 0, 1, 0, 0));
    add_row(mk(OP_RECLAIM, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_req(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_QUANTUM_LOW, 16'd300);
          write_reg(CFG_QUANTUM_MID, 16'd200);
          write_reg(CFG_QUANTUM_HIGH, 16'd100);
          write_reg(CFG_TICK_STEP, 16'd10);
        end
        1: begin
          write_reg(CFG_QUANTUM_LOW, 16'd1);
          write_reg(CFG_QUANTUM_MID, 16'd1);
          write_reg(CFG_QUANTUM_HIGH, 16'd1);
          write_reg(CFG_TICK_STEP, 16'd255);
        end
        2: begin
          write_reg(CFG_QUANTUM_LOW, 16'hFFFF);
          write_reg(CFG_QUANTUM_MID, 16'hFFFF);
          write_reg(CFG_QUANTUM_HIGH, 16'hFFFF);
          write_reg(CFG_TICK_STEP, 16'd1);
        end
        default: begin
          write_reg(CFG_QUANTUM_LOW, 16'($urandom_range(65535, 1)));
          write_reg(CFG_QUANTUM_MID, 16'($urandom_range(400, 1)));
          write_reg(CFG_QUANTUM_HIGH, 16'($urandom_range(100, 1)));
          write_reg(CFG_TICK_STEP, 16'($urandom_range(255, 1)));
        end
      endcase
      for (int n = 0; n < 95; n++) begin
        quiet = (ph == 2 && n >= 20 && n < 70);
        send_req(random_cmd(), 0, none);
      end
      quiet = 0;
    end

    req_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d requests sent, %0d results checked over four quantum settings",
             sent, checked);
    $display("%0d mismatches", errors);
    if (errors == 0 && result_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
